[src/olt_pkg.sv]
// ============================================================================
// olt_pkg: ordered list table engine package
// Shared widths, request/status codes and the control bundle that the top
// level broadcasts to every cell of the list.
// ============================================================================
package olt_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int WORD_BITS_DEF = 32;

    // Fixed widths of the transfer fields
    localparam int KIND_W = 3;
    localparam int POS_W  = 5;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int FIDX_W = 5;
    localparam int CNT_W  = 5;

    // Index/count width inside the list; covers counts up to 511 entries
    localparam int IDX_W = 9;

    typedef enum logic [KIND_W-1:0] {
        K_PUSH   = 3'd0,
        K_INSERT = 3'd1,
        K_DELETE = 3'd2,
        K_READ   = 3'd3,
        K_POP    = 3'd4,
        K_FIND   = 3'd5,
        K_REMOVE = 3'd6
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CO_HOLD    = 3'd0,
        CO_CMP     = 3'd1,
        CO_PUSH    = 3'd2,
        CO_INSERT  = 3'd3,
        CO_DELETE  = 3'd4,
        CO_SQUEEZE = 3'd5
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [IDX_W-1:0] pos;
        logic [IDX_W-1:0] used;
    } t_cell_ctl;

endpackage

[src/olt_ifs.sv]
// ============================================================================
// olt_ifs: request and response channels
// Valid/ready channels; a transfer happens on a rising edge with both high.
// ============================================================================
interface olt_req_if;
    logic                               valid;
    logic                               ready;
    logic        [olt_pkg::KIND_W-1:0]  kind;
    logic        [olt_pkg::POS_W-1:0]   position;
    logic signed [olt_pkg::VAL_W-1:0]   value;

    modport source (output valid, kind, position, value, input ready);
    modport sink   (input valid, kind, position, value, output ready);
endinterface

interface olt_rsp_if;
    logic                               valid;
    logic                               ready;
    logic        [olt_pkg::STAT_W-1:0]  status;
    logic signed [olt_pkg::VAL_W-1:0]   data;
    logic signed [olt_pkg::FIDX_W-1:0]  found_index;
    logic        [olt_pkg::CNT_W-1:0]   count;

    modport source (output valid, status, data, found_index, count, input ready);
    modport sink   (input valid, status, data, found_index, count, output ready);
endinterface

[src/ordered_list_table_engine.sv]
// A transferred request is held in EXEC; its response is registered when it completes,
//   which waits for a free response register. A new request is taken only in IDLE;
//   remove all first takes one squeeze step per matching entry through the cell row.
// A pending response does not block the next request transfer.
// Reset (i_rst_n low, synchronous): count, FSM and response valid clear;
//   entry words are not cleared and are only ever read below the count.
// ============================================================================
// ordered_list_table_engine: ordered list of signed words
// Push, insert, delete, read, pop, find and remove-all on a row of cells.
// ============================================================================
module ordered_list_table_engine #(
    parameter int DEPTH     = olt_pkg::DEPTH_DEF,
    parameter int WORD_BITS = olt_pkg::WORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    olt_req_if.sink     i_req,
    olt_rsp_if.source   o_rsp
);
    import olt_pkg::*;

    localparam int UW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    // ------------------------------------------------------------------
    // Control and request registers
    // ------------------------------------------------------------------
    t_state                 r_state;
    logic [UW-1:0]          r_used;
    t_kind                  r_kind;
    logic [POS_W-1:0]       r_pos;
    logic [WORD_BITS-1:0]   r_val;

    // Response register
    logic                   r_out_valid;
    t_status                r_status;
    logic [VAL_W-1:0]       r_data;
    logic [FIDX_W-1:0]      r_fidx;
    logic [CNT_W-1:0]       r_count;

    logic                   w_accept;
    logic [WORD_BITS-1:0]   w_in_val;
    logic [IDX_W-1:0]       w_used_x;
    logic [IDX_W-1:0]       w_pos_x;
    logic                   w_full;
    logic                   w_any;
    logic                   w_out_free;
    logic                   w_squeeze;
    logic                   w_fire;

    t_cell_ctl              w_ctl;
    logic [WORD_BITS-1:0]   w_cell_val;
    t_cell_op               w_done_op;
    t_status                w_status;
    logic [VAL_W-1:0]       w_data;
    logic [FIDX_W-1:0]      w_fidx;
    logic [UW-1:0]          w_done_used;

    // Cell row wiring; the chains run from cell 0 upward
    logic [WORD_BITS-1:0]   w_entry [DEPTH];
    logic                   w_match [DEPTH];
    logic [WORD_BITS-1:0]   w_rd    [DEPTH+1];
    logic                   w_pfx   [DEPTH+1];
    logic [IDX_W-1:0]       w_fidx_c[DEPTH+1];

    assign w_accept = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    // Incoming 32-bit value, sign-extended or cut to the stored word width
    assign w_in_val = WORD_BITS'(i_req.value);

    assign w_used_x   = IDX_W'(r_used);
    assign w_pos_x    = IDX_W'(r_pos);
    assign w_full     = (w_used_x >= IDX_W'(DEPTH));
    assign w_any      = w_pfx[DEPTH];
    assign w_out_free = !r_out_valid || o_rsp.ready;

    // Remove all: one squeeze per cycle while any flagged match is left
    assign w_squeeze = (r_state == S_EXEC) && (r_kind == K_REMOVE) && w_any;
    assign w_fire    = (r_state == S_EXEC) && !w_squeeze && w_out_free;

    // ------------------------------------------------------------------
    // Cell row
    // ------------------------------------------------------------------
    assign w_rd[0]     = '0;
    assign w_pfx[0]    = 1'b0;
    assign w_fidx_c[0] = '0;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [WORD_BITS-1:0] w_left;
        logic [WORD_BITS-1:0] w_right;
        logic                 w_rmatch;

        if (k == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_entry[k-1];
        end

        if (k == DEPTH - 1) begin : g_last
            assign w_right  = '0;
            assign w_rmatch = 1'b0;
        end else begin : g_mid_r
            assign w_right  = w_entry[k+1];
            assign w_rmatch = w_match[k+1];
        end

        olt_cell #(
            .WORD_BITS (WORD_BITS),
            .IDX       (k)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_value       (w_cell_val),
            .i_left        (w_left),
            .i_right       (w_right),
            .i_right_match (w_rmatch),
            .i_rd          (w_rd[k]),
            .i_pfx         (w_pfx[k]),
            .i_fidx        (w_fidx_c[k]),
            .o_entry       (w_entry[k]),
            .o_match       (w_match[k]),
            .o_rd          (w_rd[k+1]),
            .o_pfx         (w_pfx[k+1]),
            .o_fidx        (w_fidx_c[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Result and update for the request held in EXEC
    // ------------------------------------------------------------------
    always_comb begin
        w_status    = ST_OK;
        w_data      = '0;
        w_fidx      = '1;
        w_done_used = r_used;
        w_done_op   = CO_HOLD;
        unique case (r_kind)
            K_PUSH: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_done_op   = CO_PUSH;
                    w_done_used = r_used + UW'(1);
                end
            end
            K_INSERT: begin
                // range is checked ahead of fullness
                if (w_pos_x > w_used_x) begin
                    w_status = ST_RANGE;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_done_op   = CO_INSERT;
                    w_done_used = r_used + UW'(1);
                end
            end
            K_DELETE: begin
                if (w_pos_x >= w_used_x) begin
                    w_status = ST_RANGE;
                end else begin
                    w_done_op   = CO_DELETE;
                    w_done_used = r_used - UW'(1);
                end
            end
            K_READ: begin
                if (w_pos_x >= w_used_x) begin
                    w_status = ST_RANGE;
                end else begin
                    w_data = VAL_W'(signed'(w_rd[DEPTH]));
                end
            end
            K_POP: begin
                if (r_used == '0) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_data      = VAL_W'(signed'(w_rd[DEPTH]));
                    w_done_used = r_used - UW'(1);
                end
            end
            K_FIND: begin
                if (w_any) begin
                    w_fidx = w_fidx_c[DEPTH][FIDX_W-1:0];
                end
            end
            K_REMOVE: begin
                // all matches already squeezed out by the time this fires
            end
            default: begin
                // unused code: no effect
            end
        endcase
    end

    // Broadcast control: compare on the transfer cycle, then squeeze or commit
    always_comb begin
        w_ctl.used = w_used_x;
        w_ctl.pos  = (r_kind == K_POP) ? (w_used_x - IDX_W'(1)) : w_pos_x;
        w_ctl.op   = CO_HOLD;
        w_cell_val = r_val;
        if (r_state == S_IDLE) begin
            w_cell_val = w_in_val;
            if (w_accept) begin
                w_ctl.op = CO_CMP;
            end
        end else if (w_squeeze) begin
            w_ctl.op = CO_SQUEEZE;
        end else if (w_fire) begin
            w_ctl.op = w_done_op;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_state <= S_EXEC;
            end
            if (w_squeeze) begin
                r_used <= r_used - UW'(1);
            end
            if (w_fire) begin
                r_state     <= S_IDLE;
                r_used      <= w_done_used;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= t_kind'(i_req.kind);
            r_pos  <= i_req.position;
            r_val  <= w_in_val;
        end
        if (w_fire) begin
            r_status <= w_status;
            r_data   <= w_data;
            r_fidx   <= w_fidx;
            r_count  <= CNT_W'(w_done_used);
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.data        = r_data;
    assign o_rsp.found_index = r_fidx;
    assign o_rsp.count       = r_count;

`ifndef ASSERT_OFF
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_used_x <= IDX_W'(DEPTH))
        else $error("entry count above capacity");

    a_squeeze_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_squeeze |=> (r_used == $past(r_used) - UW'(1)))
        else $error("remove-all step did not drop one entry");

    a_fire_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("completed request did not post a response");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (w_status == ST_FULL)) |-> (w_used_x == IDX_W'(DEPTH)))
        else $error("full status on a list with room");
`endif

endmodule

[src/olt_cell.sv]
// ============================================================================
// olt_cell: one list slot
// Holds one entry and its match flag; shifts with its neighbors and feeds
// the read, match-prefix and first-match index chains.
// ============================================================================
module olt_cell #(
    parameter int WORD_BITS = olt_pkg::WORD_BITS_DEF,
    parameter int IDX       = 0
) (
    input  logic                        i_clk,
    input  olt_pkg::t_cell_ctl          i_ctl,
    input  logic [WORD_BITS-1:0]        i_value,
    input  logic [WORD_BITS-1:0]        i_left,
    input  logic [WORD_BITS-1:0]        i_right,
    input  logic                        i_right_match,
    input  logic [WORD_BITS-1:0]        i_rd,
    input  logic                        i_pfx,
    input  logic [olt_pkg::IDX_W-1:0]   i_fidx,
    output logic [WORD_BITS-1:0]        o_entry,
    output logic                        o_match,
    output logic [WORD_BITS-1:0]        o_rd,
    output logic                        o_pfx,
    output logic [olt_pkg::IDX_W-1:0]   o_fidx
);
    import olt_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(IDX);
    localparam logic [IDX_W-1:0] MY_NEXT = IDX_W'(IDX + 1);

    logic [WORD_BITS-1:0] r_entry, n_entry;
    logic                 r_match, n_match;
    logic                 w_at_pos;
    logic                 w_pfx;

    assign w_at_pos = (MY_IDX == i_ctl.pos);
    assign w_pfx    = i_pfx | r_match;

    assign o_entry = r_entry;
    assign o_match = r_match;
    assign o_rd    = i_rd | (w_at_pos ? r_entry : '0);
    assign o_pfx   = w_pfx;
    assign o_fidx  = i_fidx | ((r_match && !i_pfx) ? MY_IDX : '0);

    always_comb begin
        n_entry = r_entry;
        n_match = r_match;
        unique case (i_ctl.op)
            CO_HOLD: begin
            end
            CO_CMP: begin
                n_match = (MY_IDX < i_ctl.used) && (r_entry == i_value);
            end
            CO_PUSH: begin
                if (MY_IDX == i_ctl.used) begin
                    n_entry = i_value;
                end
            end
            CO_INSERT: begin
                if (w_at_pos) begin
                    n_entry = i_value;
                end else if ((MY_IDX > i_ctl.pos) && (MY_IDX <= i_ctl.used)) begin
                    n_entry = i_left;
                end
            end
            CO_DELETE: begin
                if ((MY_IDX >= i_ctl.pos) && (MY_NEXT < i_ctl.used)) begin
                    n_entry = i_right;
                end
            end
            CO_SQUEEZE: begin
                // everything from the first match upward slides down one slot
                if (w_pfx) begin
                    n_entry = i_right;
                    n_match = i_right_match;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_match <= n_match;
    end

endmodule

[verif/tb_ordered_list_table_engine.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_ordered_list_table_engine: self-checking bench for the ordered list
// A table of directed requests covers the empty, full and out-of-range
// corners, then random requests drift the fill level up and down. Each
// response is checked field by field against the list model or its typed row.
// ============================================================================
module tb_ordered_list_table_engine;
    import olt_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int LIST_DEPTH     = DEPTH_DEF;
    localparam int RANDOM_ITEMS   = 175;    // per idling phase
    localparam int STALL_LIMIT    = 4000;   // cycles with no transfer at all
    localparam int DRAIN_CYCLES   = 40;     // covers a full remove-all pass
    localparam int PRINT_LIMIT    = 40;
    localparam int NUM_ROWS       = 21;
    localparam int POOL_N         = 6;

    // Kind code the block ignores; not a member of t_kind
    localparam logic [KIND_W-1:0]        KIND_UNUSED = 3'd7;
    localparam logic signed [FIDX_W-1:0] FIDX_NONE   = '1;
    localparam logic signed [VAL_W-1:0]  WORD_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0]  WORD_MIN    = 32'sh8000_0000;

    typedef struct packed {
        t_status                    status;
        logic signed [VAL_W-1:0]    data;
        logic signed [FIDX_W-1:0]   found_index;
        logic        [CNT_W-1:0]    count;
    } t_list_rsp;

    // One row of the directed table; typed rows carry their own expected
    // response, the rest are checked against the list model.
    typedef struct packed {
        logic        [KIND_W-1:0]   kind;
        logic        [POS_W-1:0]    position;
        logic signed [VAL_W-1:0]    value;
        int                         repeats;
        bit                         typed;
        t_list_rsp                  exp_rsp;
    } t_list_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    olt_req_if req_if ();
    olt_rsp_if rsp_if ();

    ordered_list_table_engine i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // List model: its own copy of the entries and the length
    // ------------------------------------------------------------------------
    logic signed [VAL_W-1:0] list_words [LIST_DEPTH];
    int                      list_len;
    t_list_rsp               pending_rsp [$];

    int mismatches  = 0;
    int rsp_seen    = 0;
    int idle_cycles = 0;
    int src_idle_pct;
    int rcv_idle_pct;

    // Small set of recurring words so find and remove-all hit often
    logic signed [VAL_W-1:0] common_words [POOL_N] =
        '{32'sd0, 32'sd1, -32'sd1, WORD_MIN, WORD_MAX, 32'sh5A5A_5A5A};

    t_list_row dir_rows [NUM_ROWS] = '{
        // empty list: every failing kind, plus find and remove on nothing
        t_list_row'{K_POP,    5'd0,  32'sd0, 1, 1'b1, t_list_rsp'{ST_EMPTY, 32'sd0, FIDX_NONE, 5'd0}},
        t_list_row'{K_READ,   5'd0,  32'sd0, 1, 1'b1, t_list_rsp'{ST_RANGE, 32'sd0, FIDX_NONE, 5'd0}},
        t_list_row'{K_DELETE, 5'd0,  32'sd0, 1, 1'b1, t_list_rsp'{ST_RANGE, 32'sd0, FIDX_NONE, 5'd0}},
        t_list_row'{K_FIND,   5'd0,  32'sd7, 1, 1'b1, t_list_rsp'{ST_OK,    32'sd0, FIDX_NONE, 5'd0}},
        t_list_row'{K_REMOVE, 5'd0,  32'sd7, 1, 1'b1, t_list_rsp'{ST_OK,    32'sd0, FIDX_NONE, 5'd0}},
        t_list_row'{K_INSERT, 5'd1,  32'sd3, 1, 1'b1, t_list_rsp'{ST_RANGE, 32'sd0, FIDX_NONE, 5'd0}},
        // extreme words in, and the second one read back out
        t_list_row'{K_INSERT, 5'd0,  WORD_MAX, 1, 1'b1, t_list_rsp'{ST_OK, 32'sd0, FIDX_NONE, 5'd1}},
        t_list_row'{K_PUSH,   5'd0,  WORD_MIN, 1, 1'b1, t_list_rsp'{ST_OK, 32'sd0, FIDX_NONE, 5'd2}},
        t_list_row'{K_READ,   5'd1,  32'sd0,   1, 1'b1, t_list_rsp'{ST_OK, WORD_MIN, FIDX_NONE, 5'd2}},
        // ignored kind leaves everything alone
        t_list_row'{KIND_UNUSED, 5'd31, -32'sd1, 1, 1'b1,
                    t_list_rsp'{ST_OK, 32'sd0, FIDX_NONE, 5'd2}},
        // fill up to the last slot, last one by insert
        t_list_row'{K_PUSH,   5'd0,  32'sd7,  13, 1'b0, '0},
        t_list_row'{K_INSERT, 5'd15, -32'sd1,  1, 1'b0, '0},
        // full list: fullness vs range ordering on insert
        t_list_row'{K_PUSH,   5'd0,  32'sd0, 1, 1'b1, t_list_rsp'{ST_FULL,  32'sd0, FIDX_NONE, 5'd16}},
        t_list_row'{K_INSERT, 5'd16, 32'sd0, 1, 1'b1, t_list_rsp'{ST_FULL,  32'sd0, FIDX_NONE, 5'd16}},
        t_list_row'{K_INSERT, 5'd17, 32'sd0, 1, 1'b1, t_list_rsp'{ST_RANGE, 32'sd0, FIDX_NONE, 5'd16}},
        t_list_row'{K_READ,   5'd31, 32'sd0, 1, 1'b1, t_list_rsp'{ST_RANGE, 32'sd0, FIDX_NONE, 5'd16}},
        // full-list search and a bulk remove, then shrink
        t_list_row'{K_FIND,   5'd0,  32'sd7,  1, 1'b0, '0},
        t_list_row'{K_READ,   5'd0,  32'sd0,  1, 1'b0, '0},
        t_list_row'{K_REMOVE, 5'd0,  32'sd7,  1, 1'b0, '0},
        t_list_row'{K_DELETE, 5'd1,  32'sd0,  1, 1'b0, '0},
        t_list_row'{K_POP,    5'd0,  32'sd0,  1, 1'b0, '0}
    };

    // Applies one request to the model list and returns its response
    function automatic t_list_rsp list_apply(input logic [KIND_W-1:0] kind,
                                             input logic [POS_W-1:0] pos,
                                             input logic signed [VAL_W-1:0] val);
        t_list_rsp r;
        int        p;
        int        i;
        int        kept;
        bit        hit;
        r.status      = ST_OK;
        r.data        = '0;
        r.found_index = FIDX_NONE;
        p             = int'(pos);
        hit           = 1'b0;
        kept          = 0;
        case (kind)
            K_PUSH: begin
                if (list_len >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    list_words[list_len] = val;
                    list_len++;
                end
            end
            K_INSERT: begin
                // range is checked before fullness
                if (p > list_len) begin
                    r.status = ST_RANGE;
                end else if (list_len >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = list_len; i > p; i--)
                        list_words[i] = list_words[i-1];
                    list_words[p] = val;
                    list_len++;
                end
            end
            K_DELETE: begin
                if (p >= list_len) begin
                    r.status = ST_RANGE;
                end else begin
                    for (i = p; i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                end
            end
            K_READ: begin
                if (p >= list_len)
                    r.status = ST_RANGE;
                else
                    r.data = list_words[p];
            end
            K_POP: begin
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    list_len--;
                    r.data = list_words[list_len];
                end
            end
            K_FIND: begin
                for (i = 0; i < list_len; i++) begin
                    if (!hit && list_words[i] == val) begin
                        r.found_index = FIDX_W'(i);
                        hit = 1'b1;
                    end
                end
            end
            K_REMOVE: begin
                // survivors close up in order
                for (i = 0; i < list_len; i++) begin
                    if (list_words[i] != val) begin
                        list_words[kept] = list_words[i];
                        kept++;
                    end
                end
                list_len = kept;
            end
            default: ;
        endcase
        r.count = CNT_W'(list_len);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("[%0t] ERROR rsp %0d: %s", $time, rsp_seen, msg);
    endtask

    // ------------------------------------------------------------------------
    // Request side: optional gap, then hold the request until it transfers
    // ------------------------------------------------------------------------
    task automatic send_req(input logic [KIND_W-1:0] kind,
                            input logic [POS_W-1:0] pos,
                            input logic signed [VAL_W-1:0] val,
                            input bit typed,
                            input t_list_rsp typed_rsp);
        t_list_rsp pred;
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.kind     <= kind;
        req_if.position <= pos;
        req_if.value    <= val;
        do @(posedge i_clk); while (!req_if.ready);
        // model steps at the transfer edge even for typed rows
        pred = list_apply(kind, pos, val);
        pending_rsp.push_back(typed ? typed_rsp : pred);
    endtask

    // Random requests; the fill goal moves every few dozen so the list
    // spends time empty, full and in between.
    task automatic run_random(input int n_items);
        int                      done;
        int                      roll;
        int                      goal;
        int                      hi;
        logic [KIND_W-1:0]       kind;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;
        done = 0;
        goal = LIST_DEPTH / 2;
        while (done < n_items) begin
            if (done % 32 == 0) begin
                case ($urandom_range(3))
                    0:       goal = 0;
                    1:       goal = LIST_DEPTH;
                    default: goal = $urandom_range(LIST_DEPTH);
                endcase
            end

            roll = $urandom_range(99);
            if (roll < 2)
                kind = KIND_UNUSED;
            else if (roll < 45)
                kind = (list_len < goal) ? ($urandom_range(1) ? K_INSERT : K_PUSH)
                                         : ($urandom_range(1) ? K_DELETE : K_POP);
            else if (roll < 60)
                kind = K_READ;
            else if (roll < 72)
                kind = K_FIND;
            else if (roll < 80)
                kind = K_REMOVE;
            else
                kind = KIND_W'($urandom_range(int'(K_REMOVE)));

            // mostly in range, some at the edges, a few with high bits set
            hi   = (kind == K_INSERT) ? list_len : ((list_len > 0) ? list_len - 1 : 0);
            roll = $urandom_range(99);
            if (roll < 85)
                pos = POS_W'($urandom_range(hi));
            else if (roll < 97)
                pos = POS_W'($urandom_range(LIST_DEPTH));
            else
                pos = POS_W'($urandom_range(31, LIST_DEPTH + 1));

            if ($urandom_range(99) < 55)
                val = common_words[$urandom_range(POOL_N - 1)];
            else
                val = $urandom;

            send_req(kind, pos, val, 1'b0, '0);
            if (kind != KIND_UNUSED)
                done++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Response side: random back-pressure and the field checks
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_list_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_rsp.size() == 0) begin
                report_mismatch("response transfer with nothing pending");
            end else begin
                want = pending_rsp.pop_front();
                if (rsp_if.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              rsp_if.status, want.status));
                if (rsp_if.data !== want.data)
                    report_mismatch($sformatf("data %h, want %h",
                                              rsp_if.data, want.data));
                if (rsp_if.found_index !== want.found_index)
                    report_mismatch($sformatf("found_index %0d, want %0d",
                                              rsp_if.found_index, want.found_index));
                if (rsp_if.count !== want.count)
                    report_mismatch($sformatf("count %0d, want %0d",
                                              rsp_if.count, want.count));
            end
            rsp_seen++;
        end
    end

    // Watchdog: any transfer on either side restarts the count
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d cycles without a transfer", idle_cycles);
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int r;
        int n;
        i_rst_n         <= 1'b0;
        req_if.valid    <= 1'b0;
        req_if.kind     <= '0;
        req_if.position <= '0;
        req_if.value    <= '0;
        list_len        = 0;
        src_idle_pct    = 6;
        rcv_idle_pct    = 62;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < NUM_ROWS; r++)
            for (n = 0; n < dir_rows[r].repeats; n++)
                send_req(dir_rows[r].kind, dir_rows[r].position, dir_rows[r].value,
                         dir_rows[r].typed, dir_rows[r].exp_rsp);

        // slow receiver, then slow sender, then full speed both ways
        run_random(RANDOM_ITEMS);
        src_idle_pct = 62;
        rcv_idle_pct = 6;
        run_random(RANDOM_ITEMS);
        src_idle_pct = 0;
        rcv_idle_pct = 0;
        run_random(RANDOM_ITEMS);
        req_if.valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge i_clk);
        // catch any stray response after the last expected one
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[files.f]
src/olt_pkg.sv
src/olt_ifs.sv
src/olt_cell.sv
src/ordered_list_table_engine.sv
verif/tb_ordered_list_table_engine.sv
